/* rtl/kpd_pkg.sv */
`default_nettype none

package kpd_pkg;

  // keycodes and symbols
  localparam logic [9:0] KC_KP0   = 10'd82;
  localparam logic [6:0] SYM_NONE = 7'("-");
  localparam logic [6:0] SYM_STAR = 7'("*");
  localparam logic [6:0] SYM_ZERO = 7'("0");

  // operation codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // key action codes
  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_REPEAT  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PHONE_MODE    = 2'd0;
  localparam logic [1:0] REG_PAIR_WINDOW   = 2'd1;
  localparam logic [1:0] REG_REPEAT_SUPPR  = 2'd2;

  localparam logic [19:0] PAIR_WINDOW_RST  = 20'd30000;
  localparam logic [19:0] REPEAT_SUPPR_RST = 20'd50000;

  typedef struct packed {
    logic       operation;
    logic [9:0] key_code;
    logic [1:0] key_action;
    logic [31:0] time_us;
  } kpd_item_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic [9:0] key_id;
    logic       valid_res;
    logic       last;
  } kpd_res_t;

  typedef struct packed {
    logic        phone_mode;
    logic [19:0] pair_window_us;
    logic [19:0] repeat_suppress_us;
  } kpd_cfg_t;

  localparam kpd_res_t RES_NONE = '{symbol: SYM_NONE, key_id: 10'd0,
                                    valid_res: 1'b0, last: 1'b0};

  // keys shared by both layouts
  function automatic logic [6:0] common_sym(input logic [9:0] c);
    logic [6:0] s;
    unique case (c)
      10'd11:  s = 7'("0");
      10'd2:   s = 7'("1");
      10'd3:   s = 7'("2");
      10'd4:   s = 7'("3");
      10'd5:   s = 7'("4");
      10'd6:   s = 7'("5");
      10'd7:   s = 7'("6");
      10'd8:   s = 7'("7");
      10'd9:   s = 7'("8");
      10'd10:  s = 7'("9");
      10'd30:  s = 7'("A");
      10'd48:  s = 7'("B");
      10'd46:  s = 7'("C");
      10'd32:  s = 7'("D");
      10'd28:  s = 7'("#");
      10'd52:  s = 7'("*");
      10'd45:  s = 7'("X");
      10'd21:  s = 7'("Y");
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] calc_sym(input logic [9:0] c);
    logic [6:0] s;
    unique case (c)
      10'd82:  s = 7'("0");
      10'd79:  s = 7'("1");
      10'd80:  s = 7'("2");
      10'd81:  s = 7'("3");
      10'd75:  s = 7'("4");
      10'd76:  s = 7'("5");
      10'd77:  s = 7'("6");
      10'd71:  s = 7'("7");
      10'd72:  s = 7'("8");
      10'd73:  s = 7'("9");
      10'd98:  s = 7'("A");
      10'd55:  s = 7'("B");
      10'd74:  s = 7'("C");
      10'd78:  s = 7'("D");
      10'd96:  s = 7'("#");
      10'd83:  s = 7'("*");
      10'd69:  s = 7'("X");
      10'd14:  s = 7'("Y");
      default: s = common_sym(c);
    endcase
    return s;
  endfunction

  function automatic logic [6:0] phone_sym(input logic [9:0] c);
    logic [6:0] s;
    unique case (c)
      10'd79:  s = 7'("7");
      10'd80:  s = 7'("8");
      10'd81:  s = 7'("9");
      10'd75:  s = 7'("4");
      10'd76:  s = 7'("5");
      10'd77:  s = 7'("6");
      10'd71:  s = 7'("1");
      10'd72:  s = 7'("2");
      10'd73:  s = 7'("3");
      10'd14:  s = 7'("A");
      10'd74:  s = 7'("B");
      10'd78:  s = 7'("C");
      10'd96:  s = 7'("D");
      10'd83:  s = 7'("#");
      default: s = common_sym(c);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/kpd_cfg.sv */
`default_nettype none

module kpd_cfg
  import kpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output kpd_cfg_t         cfg_o
);

  kpd_cfg_t   cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PHONE_MODE:   cfg_d.phone_mode         = pwdata[0];
        REG_PAIR_WINDOW:  cfg_d.pair_window_us     = pwdata[19:0];
        REG_REPEAT_SUPPR: cfg_d.repeat_suppress_us = pwdata[19:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PHONE_MODE:   prdata = {31'd0, cfg_q.phone_mode};
      REG_PAIR_WINDOW:  prdata = {12'd0, cfg_q.pair_window_us};
      REG_REPEAT_SUPPR: prdata = {12'd0, cfg_q.repeat_suppress_us};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phone_mode         <= 1'b0;
      cfg_q.pair_window_us     <= PAIR_WINDOW_RST;
      cfg_q.repeat_suppress_us <= REPEAT_SUPPR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/kpd_core.sv */
`default_nettype none

module kpd_core
  import kpd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  kpd_item_t      item_i,
  input  kpd_cfg_t       cfg_i,
  output kpd_res_t       res0_o,
  output kpd_res_t       res1_o,
  output logic           two_o
);

  logic                 zp_q, zp_d;
  logic [TIME_BITS-1:0] ps_q, ps_d;
  logic [9:0]           pc_q, pc_d;
  logic                 pk_q, pk_d;
  logic [TIME_BITS-1:0] pt_q, pt_d;
  logic [6:0]           hs_q, hs_d;
  logic [9:0]           hc_q, hc_d;
  logic                 hk_q, hk_d;

  logic [TIME_BITS+31:0] t_wide;
  logic [TIME_BITS-1:0]  t_now;
  logic [TIME_BITS-1:0]  pend_age;
  logic [TIME_BITS-1:0]  press_age;
  logic                  expired;
  logic                  suppress;
  logic                  phone;
  logic                  do_plain;
  logic                  second;
  logic [6:0]            sym;
  kpd_res_t              pr;

  // timestamps masked to the time width, differences wrap
  assign t_wide    = {{TIME_BITS{1'b0}}, item_i.time_us};
  assign t_now     = t_wide[TIME_BITS-1:0];
  assign pend_age  = t_now - ps_q;
  assign press_age = t_now - pt_q;
  assign expired   = pend_age >= TIME_BITS'(cfg_i.pair_window_us);
  assign phone     = cfg_i.phone_mode;
  assign sym       = phone ? phone_sym(item_i.key_code) : calc_sym(item_i.key_code);

  always_comb begin
    zp_d = zp_q; ps_d = ps_q; pc_d = pc_q; pk_d = pk_q; pt_d = pt_q;
    hs_d = hs_q; hc_d = hc_q; hk_d = hk_q;
    res0_o   = RES_NONE;
    res1_o   = RES_NONE;
    pr       = RES_NONE;
    do_plain = 1'b0;
    second   = 1'b0;
    suppress = 1'b0;

    // deferred keypad zero resolves first
    if (phone && zp_q) begin
      if (expired || (item_i.operation == OP_KEY && item_i.key_action == ACT_PRESS &&
                      item_i.key_code != KC_KP0)) begin
        zp_d = 1'b0;
        hs_d = SYM_STAR; hc_d = KC_KP0; hk_d = 1'b1;
        res0_o = '{symbol: SYM_STAR, key_id: KC_KP0, valid_res: 1'b1, last: 1'b0};
        do_plain = (item_i.operation == OP_KEY);
        second   = (item_i.operation == OP_KEY);
      end else if (item_i.operation == OP_KEY && item_i.key_action == ACT_PRESS) begin
        // second keypad zero inside the window
        zp_d = 1'b0;
        hs_d = SYM_ZERO; hc_d = KC_KP0; hk_d = 1'b1;
        res0_o = '{symbol: SYM_ZERO, key_id: KC_KP0, valid_res: 1'b1, last: 1'b0};
      end
    end else if (item_i.operation == OP_KEY) begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      unique case (item_i.key_action)
        ACT_PRESS: begin
          if (phone && item_i.key_code == KC_KP0) begin
            zp_d = 1'b1;
            ps_d = t_now;
          end else begin
            suppress = !phone && item_i.key_code == KC_KP0 && pk_q && pc_q == KC_KP0 &&
                       press_age < TIME_BITS'(cfg_i.repeat_suppress_us);
            if (!suppress) begin
              if (!phone) begin
                pc_d = item_i.key_code; pk_d = 1'b1; pt_d = t_now;
              end
              hs_d = sym; hc_d = item_i.key_code; hk_d = 1'b1;
              pr = '{symbol: sym, key_id: item_i.key_code,
                     valid_res: sym != SYM_NONE, last: 1'b0};
            end
          end
        end
        ACT_RELEASE: begin
          if (hk_d && item_i.key_code == hc_d) begin
            hs_d = SYM_NONE; hc_d = 10'd0; hk_d = 1'b0;
          end
        end
        ACT_REPEAT: begin
          if (hs_d != SYM_NONE) begin
            pr = '{symbol: hs_d, key_id: hc_d, valid_res: 1'b1, last: 1'b0};
          end
        end
        default: pr = RES_NONE;
      endcase
      if (second) res1_o = pr;
      else        res0_o = pr;
    end

    res0_o.last = !second;
    res1_o.last = 1'b1;
  end

  assign two_o = second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q <= 1'b0;
      ps_q <= '0;
      pc_q <= 10'd0;
      pk_q <= 1'b0;
      pt_q <= '0;
      hs_q <= SYM_NONE;
      hc_q <= 10'd0;
      hk_q <= 1'b0;
    end else if (fire_i) begin
      zp_q <= zp_d;
      ps_q <= ps_d;
      pc_q <= pc_d;
      pk_q <= pk_d;
      pt_q <= pt_d;
      hs_q <= hs_d;
      hc_q <= hc_d;
      hk_q <= hk_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/kpd_res_fifo.sv */
`default_nettype none

module kpd_res_fifo
  import kpd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic push_two_i,
  input  kpd_res_t  d0_i,
  input  kpd_res_t  d1_i,
  input  wire logic pop_i,
  output logic      room2_o,
  output logic      valid_o,
  output kpd_res_t  head_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  kpd_res_t        mem_q [DEPTH];
  logic [AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   n_push;
  logic [CW-1:0]   n_pop;
  logic [AW-1:0]   wp_next;

  assign n_push  = push_i ? (push_two_i ? CW'(2) : CW'(1)) : CW'(0);
  assign n_pop   = pop_i ? CW'(1) : CW'(0);
  assign wp_next = wp_q + AW'(1);
  assign cnt_d   = cnt_q + n_push - n_pop;
  assign wp_d    = wp_q + n_push[AW-1:0];
  assign rp_d    = rp_q + n_pop[AW-1:0];
  // at least two entries free after this cycle's read
  assign room2_o = (cnt_q - n_pop) <= CW'(DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= d0_i;
      if (push_two_i) mem_q[wp_next] <= d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/keypad_event_decoder.sv */
// A transferred item waits in the input register, then is decoded into the result queue;
// the second result of an item leaves the queue after the first.
// Throughput: one item per cycle while the queue has room for both possible results; an item
// with two results holds the output until both are read; the four-entry queue has one read port.
// Reset (rst_ni low, asynchronous): queue and input register empty, decoder state cleared,
// registers back to calculator layout, 30000 us pair window, 50000 us suppress window.
`default_nettype none

module keypad_event_decoder
  import kpd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  kpd_item_t        in_item_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output kpd_res_t         out_res_o,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  kpd_cfg_t  cfg;
  kpd_item_t item_q;
  logic      item_vld_q, item_vld_d;
  logic      fire;
  logic      room2;
  logic      pop;
  logic      two;
  kpd_res_t  res0;
  kpd_res_t  res1;

  kpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The registered item is decoded once the queue is sure to have room for
  // both of its possible results; the input stage then refills in the same cycle.
  assign pop        = out_valid_o & ~out_stall_i;
  assign fire       = item_vld_q & room2;
  assign in_stall_o = item_vld_q & ~fire;

  always_comb begin
    item_vld_d = item_vld_q;
    if (!in_stall_o) begin
      item_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  kpd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (two)
  );

  // results queue up here so the output side can stall independently
  kpd_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .push_two_i (two),
    .d0_i       (res0),
    .d1_i       (res1),
    .pop_i      (pop),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .head_o     (out_res_o)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kpd_pkg::*;

  // Action value three has no name in the package; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles with no transfer on either channel before the run is called hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to watch for stray results once nothing is due any more.
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 100;

  // One row of the directed table: a register write or an item, with an
  // optional hand-written single result.
  typedef struct packed {
    logic        is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    kpd_item_t   item;
    logic        typed;
    kpd_res_t    res;
  } drill_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  kpd_item_t   in_item_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  kpd_res_t    out_res_o;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  keypad_event_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // Decoder shadow: configuration and state, at reset values
  // ---------------------------------------------------------------------------
  logic        cfg_phone    = 1'b0;
  logic [19:0] cfg_pair_win = PAIR_WINDOW_RST;
  logic [19:0] cfg_suppress = REPEAT_SUPPR_RST;

  logic        zero_wait  = 1'b0;   // phone-mode keypad 0 deferred
  logic [31:0] zero_since = '0;
  logic [9:0]  press_code = '0;     // last calculator-mode press
  logic        press_seen = 1'b0;
  logic [31:0] press_t    = '0;
  logic [6:0]  hold_sym   = SYM_NONE;
  logic [9:0]  hold_code  = '0;
  logic        hold_seen  = 1'b0;

  kpd_res_t    due_results [$];     // results the block still owes, oldest first

  // Handshake bookkeeping, sampled mid-cycle so that nothing races the edge.
  logic        item_taken = 1'b0;
  logic        res_taken  = 1'b0;
  logic        apb_done   = 1'b0;
  logic        row_typed  = 1'b0;
  kpd_res_t    row_res    = '0;
  logic        calm       = 1'b0;   // no idling on either side while set
  int          idle_run   = 0;
  int          errors     = 0;
  logic [31:0] now_us     = '0;     // running timestamp of the random part

  // Mapped keys of both layouts, keypad 0 aside.
  logic [9:0] key_pool [0:34] = '{
    10'd2,  10'd3,  10'd4,  10'd5,  10'd6,  10'd7,  10'd8,  10'd9,  10'd10, 10'd11,
    10'd14, 10'd21, 10'd28, 10'd30, 10'd32, 10'd45, 10'd46, 10'd48, 10'd52, 10'd55,
    10'd69, 10'd71, 10'd72, 10'd73, 10'd74, 10'd75, 10'd76, 10'd77, 10'd78, 10'd79,
    10'd80, 10'd81, 10'd83, 10'd96, 10'd98
  };

  // Symbol table of both layouts in one place; the keypad block differs,
  // the main-row digits and letters are shared.
  function automatic logic [6:0] glyph(input logic phone, input logic [9:0] kc);
    logic [7:0] g;
    case (kc)
      10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8, 10'd9, 10'd10:
        g = "0" + 8'(kc) - 8'd1;
      10'd11: g = "0";
      10'd30: g = "A";
      10'd48: g = "B";
      10'd46: g = "C";
      10'd32: g = "D";
      10'd28: g = "#";
      10'd52: g = "*";
      10'd45: g = "X";
      10'd21: g = "Y";
      10'd75: g = "4";
      10'd76: g = "5";
      10'd77: g = "6";
      // phone keypads put 1-2-3 on top, calculators 7-8-9
      10'd71: g = phone ? "1" : "7";
      10'd72: g = phone ? "2" : "8";
      10'd73: g = phone ? "3" : "9";
      10'd79: g = phone ? "7" : "1";
      10'd80: g = phone ? "8" : "2";
      10'd81: g = phone ? "9" : "3";
      10'd14: g = phone ? "A" : "Y";
      10'd74: g = phone ? "B" : "C";
      10'd78: g = phone ? "C" : "D";
      10'd96: g = phone ? "D" : "#";
      10'd83: g = phone ? "#" : "*";
      // calculator only
      10'd82: g = phone ? "-" : "0";
      10'd98: g = phone ? "-" : "A";
      10'd55: g = phone ? "-" : "B";
      10'd69: g = phone ? "-" : "X";
      default: g = "-";
    endcase
    return g[6:0];
  endfunction

  function automatic void hold_key(input logic [6:0] s, input logic [9:0] kc);
    hold_sym  = s;
    hold_code = kc;
    hold_seen = 1'b1;
  endfunction

  function automatic kpd_res_t key_res(input logic [6:0] s, input logic [9:0] kc,
                                       input logic v);
    kpd_res_t r;
    r.symbol    = s;
    r.key_id    = kc;
    r.valid_res = v;
    r.last      = 1'b1;
    return r;
  endfunction

  // Key event with nothing deferred: always exactly one result.
  function automatic kpd_res_t plain_key(input logic [9:0] kc, input logic [1:0] act,
                                         input logic [31:0] t);
    kpd_res_t    r;
    logic [6:0]  s;
    logic [31:0] gap;
    r   = RES_NONE;
    gap = t - press_t;
    case (act)
      ACT_PRESS: begin
        if (cfg_phone && kc == KC_KP0) begin
          zero_wait  = 1'b1;
          zero_since = t;
        end else if (!cfg_phone && kc == KC_KP0 && press_seen && press_code == KC_KP0 &&
                     gap < {12'd0, cfg_suppress}) begin
          // second keypad 0 inside the suppress window: swallowed
        end else begin
          if (!cfg_phone) begin
            press_code = kc;
            press_seen = 1'b1;
            press_t    = t;
          end
          s = glyph(cfg_phone, kc);
          hold_key(s, kc);
          r.symbol    = s;
          r.key_id    = kc;
          r.valid_res = (s != SYM_NONE);
        end
      end
      ACT_RELEASE: begin
        if (hold_seen && kc == hold_code) begin
          hold_sym  = SYM_NONE;
          hold_code = '0;
          hold_seen = 1'b0;
        end
      end
      ACT_REPEAT: begin
        if (hold_sym != SYM_NONE) begin
          r.symbol    = hold_sym;
          r.key_id    = hold_code;
          r.valid_res = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Works out the one or two results of an item and queues them.
  function automatic void decode_item(input kpd_item_t it);
    kpd_res_t    first, second;
    logic        two;
    logic [31:0] age;
    two    = 1'b0;
    first  = RES_NONE;
    second = RES_NONE;
    age    = it.time_us - zero_since;
    if (cfg_phone && zero_wait) begin
      if (age >= {12'd0, cfg_pair_win}) begin
        // window over: the deferred zero becomes '*', then the event as usual
        zero_wait = 1'b0;
        hold_key(SYM_STAR, KC_KP0);
        first = key_res(SYM_STAR, KC_KP0, 1'b1);
        if (it.operation == OP_KEY) begin
          second = plain_key(it.key_code, it.key_action, it.time_us);
          two    = 1'b1;
        end
      end else if (it.operation == OP_KEY && it.key_action == ACT_PRESS) begin
        zero_wait = 1'b0;
        if (it.key_code == KC_KP0) begin
          hold_key(SYM_ZERO, KC_KP0);
          first = key_res(SYM_ZERO, KC_KP0, 1'b1);
        end else begin
          hold_key(SYM_STAR, KC_KP0);
          first  = key_res(SYM_STAR, KC_KP0, 1'b1);
          second = plain_key(it.key_code, it.key_action, it.time_us);
          two    = 1'b1;
        end
      end
      // polls, releases, repeats and unused actions inside the window yield a not-valid result
    end else if (it.operation == OP_KEY) begin
      first = plain_key(it.key_code, it.key_action, it.time_us);
    end
    if (two) begin
      first.last  = 1'b0;
      second.last = 1'b1;
      due_results.push_back(first);
      due_results.push_back(second);
    end else begin
      first.last = 1'b1;
      due_results.push_back(first);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mid-cycle monitor: inputs only move at the rising edge, so the values seen
  // here are the ones the next edge will act on.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : monitor
    kpd_res_t want;
    item_taken = 1'b0;
    res_taken  = 1'b0;
    apb_done   = psel && penable && pwrite && pready;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        decode_item(in_item_i);
        if (row_typed) begin
          void'(due_results.pop_back());
          due_results.push_back(row_res);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        res_taken = 1'b1;
        if (due_results.size() == 0) begin
          $display("%0t ns: result with none due: sym %0d code %0d valid %0b last %0b",
                   $time, out_res_o.symbol, out_res_o.key_id, out_res_o.valid_res,
                   out_res_o.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (want.symbol !== out_res_o.symbol || want.key_id !== out_res_o.key_id ||
              want.valid_res !== out_res_o.valid_res || want.last !== out_res_o.last) begin
            $display("%0t ns: mismatch: expected sym %0d code %0d valid %0b last %0b, %s",
                     $time, want.symbol, want.key_id, want.valid_res, want.last,
                     $sformatf("got sym %0d code %0d valid %0b last %0b",
                               out_res_o.symbol, out_res_o.key_id,
                               out_res_o.valid_res, out_res_o.last));
            errors++;
          end
        end
      end
    end
    if (item_taken || res_taken)
      idle_run = 0;
    else
      idle_run++;
  end

  // Result side: stalls about one cycle in eight, none during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 12);
  end

  initial begin : watchdog
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic kpd_item_t key_ev(input logic [9:0] kc, input logic [1:0] act,
                                       input logic [31:0] t);
    kpd_item_t it;
    it.operation  = OP_KEY;
    it.key_code   = kc;
    it.key_action = act;
    it.time_us    = t;
    return it;
  endfunction

  function automatic kpd_item_t poll_ev(input logic [31:0] t);
    kpd_item_t it;
    it            = '0;
    it.operation  = OP_POLL;
    it.time_us    = t;
    return it;
  endfunction

  function automatic drill_t row_reg(input logic [1:0] idx, input logic [31:0] val);
    drill_t d;
    d         = '0;
    d.is_reg  = 1'b1;
    d.reg_idx = idx;
    d.reg_val = val;
    return d;
  endfunction

  function automatic drill_t row_key(input kpd_item_t it);
    drill_t d;
    d      = '0;
    d.item = it;
    return d;
  endfunction

  function automatic drill_t row_chk(input kpd_item_t it, input kpd_res_t res);
    drill_t d;
    d       = '0;
    d.item  = it;
    d.typed = 1'b1;
    d.res   = res;
    return d;
  endfunction

  // Offers one item, with a random idle gap first, and returns at the edge
  // of its transfer. Valid stays high so back-to-back items need no toggle.
  task automatic send_item(input kpd_item_t it, input logic typed, input kpd_res_t res);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    row_typed   = typed;
    row_res     = res;
    do @(posedge clk_i); while (!item_taken);
  endtask

  // Stops offering and waits for every owed result.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle until pready completes the write.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!apb_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PHONE_MODE:   cfg_phone    = val[0];
      REG_PAIR_WINDOW:  cfg_pair_win = val[19:0];
      REG_REPEAT_SUPPR: cfg_suppress = val[19:0];
      default: ;
    endcase
  endtask

  task automatic pick_window(output logic [19:0] w);
    case ($urandom_range(5))
      0:       w = '0;
      1:       w = '1;
      2:       w = PAIR_WINDOW_RST;
      default: w = 20'($urandom_range(120000, 1));
    endcase
  endtask

  // Random item biased towards keypad 0 and window edges, so the deferral and
  // suppression paths are hit often; releases often target the held key.
  task automatic make_random_item(output kpd_item_t it);
    int unsigned roll;
    logic [31:0] anchor;
    logic [19:0] win;
    win    = cfg_phone ? cfg_pair_win : cfg_suppress;
    anchor = cfg_phone ? zero_since : press_t;
    roll   = $urandom_range(99);
    if (roll < 6)
      now_us = $urandom();
    else if (roll < 22)
      now_us = anchor + {12'd0, win} - 32'($urandom_range(1));
    else if (roll >= 35)
      now_us = now_us + $urandom_range(2 * int'(win) + 2);
    it         = '0;
    it.time_us = now_us;
    roll       = $urandom_range(99);
    if (roll < (cfg_phone ? 14 : 6)) begin
      // code and action of a poll are noise
      it.operation  = OP_POLL;
      it.key_code   = 10'($urandom_range(767));
      it.key_action = 2'($urandom_range(3));
    end else begin
      it.operation = OP_KEY;
      roll = $urandom_range(99);
      if (roll < 35)
        it.key_code = KC_KP0;
      else if (roll < 85)
        it.key_code = key_pool[$urandom_range(34)];
      else
        it.key_code = 10'($urandom_range(767));
      roll = $urandom_range(99);
      if (roll < 50) begin
        it.key_action = ACT_PRESS;
      end else if (roll < 75) begin
        it.key_action = ACT_RELEASE;
        if ($urandom_range(1)) it.key_code = hold_code;
      end else if (roll < 95) begin
        it.key_action = ACT_REPEAT;
      end else begin
        it.key_action = ACT_UNUSED;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    drill_t      drill [$];
    kpd_item_t   it;
    logic [19:0] w;
    int          sent;

    // calculator layout, reset windows
    drill.push_back(row_chk(poll_ev(32'd0), key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(10'd0, ACT_REPEAT, 32'd0), key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(10'd767, ACT_RELEASE, 32'd0),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(10'd0, ACT_UNUSED, 32'd0), key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd100), key_res(SYM_ZERO, KC_KP0, 1'b1)));
    // one short of the suppress window, then exactly on it
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd50099),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd50100),
                            key_res(SYM_ZERO, KC_KP0, 1'b1)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_REPEAT, 32'd50100),
                            key_res(SYM_ZERO, KC_KP0, 1'b1)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_RELEASE, 32'd50200),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    // unmapped top code: reported raw, not valid
    drill.push_back(row_chk(key_ev(10'd767, ACT_PRESS, 32'd60000),
                            key_res(SYM_NONE, 10'd767, 1'b0)));
    // suppress window across the timestamp wrap
    drill.push_back(row_key(key_ev(KC_KP0, ACT_PRESS, 32'hFFFF_FFF0)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'h0000_0010),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_reg(REG_REPEAT_SUPPR, 32'd0));
    drill.push_back(row_key(key_ev(KC_KP0, ACT_PRESS, 32'h0000_0010)));
    drill.push_back(row_reg(REG_REPEAT_SUPPR, 32'h000F_FFFF));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'h0010_000E),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    // phone layout: zero pairing
    drill.push_back(row_reg(REG_PHONE_MODE, 32'd1));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd1000),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_REPEAT, 32'd1000),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(poll_ev(32'd30999), key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd30999),
                            key_res(SYM_ZERO, KC_KP0, 1'b1)));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd50000),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(poll_ev(32'd80000), key_res(SYM_STAR, KC_KP0, 1'b1)));
    // other key while deferred: '*' then that key
    drill.push_back(row_key(key_ev(KC_KP0, ACT_PRESS, 32'd100000)));
    drill.push_back(row_key(key_ev(10'd72, ACT_PRESS, 32'd100010)));
    // deferral survives a trip to calculator layout
    drill.push_back(row_key(key_ev(KC_KP0, ACT_PRESS, 32'd200000)));
    drill.push_back(row_reg(REG_PHONE_MODE, 32'd0));
    drill.push_back(row_key(key_ev(10'd75, ACT_PRESS, 32'd200005)));
    drill.push_back(row_reg(REG_PHONE_MODE, 32'd1));
    drill.push_back(row_reg(REG_PAIR_WINDOW, 32'd0));
    drill.push_back(row_chk(poll_ev(32'd200005), key_res(SYM_STAR, KC_KP0, 1'b1)));
    // widest pair window: one short, then on it
    drill.push_back(row_reg(REG_PAIR_WINDOW, 32'h000F_FFFF));
    drill.push_back(row_chk(key_ev(KC_KP0, ACT_PRESS, 32'd300000),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(poll_ev(32'd300000 + 32'h000F_FFFE),
                            key_res(SYM_NONE, 10'd0, 1'b0)));
    drill.push_back(row_chk(poll_ev(32'd300000 + 32'h000F_FFFF),
                            key_res(SYM_STAR, KC_KP0, 1'b1)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drill[i]) begin
      if (drill[i].is_reg) begin
        settle_block();
        reg_write(drill[i].reg_idx, drill[i].reg_val);
      end else begin
        send_item(drill[i].item, drill[i].typed, drill[i].res);
      end
    end

    // Random phases, layout alternating, windows re-drawn each time.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      reg_write(REG_PHONE_MODE, 32'(phase % 2));
      pick_window(w);
      reg_write(REG_PAIR_WINDOW, {12'd0, w});
      pick_window(w);
      reg_write(REG_REPEAT_SUPPR, {12'd0, w});
      now_us = $urandom();
      calm   = (phase == 2);
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        make_random_item(it);
        send_item(it, 1'b0, RES_NONE);
        if (!(it.operation == OP_KEY && it.key_action == ACT_UNUSED)) sent++;
      end
      calm = 1'b0;
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/kpd_pkg.sv
rtl/kpd_cfg.sv
rtl/kpd_core.sv
rtl/kpd_res_fifo.sv
rtl/keypad_event_decoder.sv
bench/tb.sv
